// File: hdl/ctts_pkg.sv
// Shared types, constants and helpers for the cooperative task tick scheduler.
// Used by ctts_ctrl, ctts_dp and cooperative_task_tick_scheduler; no dependencies.
package ctts_pkg;

    // Table geometry
    localparam int TASKS   = 8;
    localparam int MAX_OUT = 8;
    localparam int IDX_W   = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int NF_W    = $clog2(TASKS + 1);
    localparam int CNT_W   = $clog2(MAX_OUT + 1);
    localparam int SLOT_W  = 3;
    localparam int BYTE_W  = 8;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_ADD  = 2'd0,
        REQ_DEL  = 2'd1,
        REQ_TICK = 2'd2,
        REQ_DISP = 2'd3
    } req_t;

    // Result status carried on the output tuser
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_UNDEF = 2'd2,
        STAT_NONE  = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SINGLE,
        S_TICK,
        S_DISP,
        S_FLUSH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // latch request, restart walk
        logic exec;       // run add or delete and load its result
        logic tick_step;  // count down one slot
        logic disp_step;  // examine one slot for pending runs
        logic flush;      // load the closing result of a walk
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic idx_last;    // walk is at the final slot
        logic slot_ready;  // current slot is valid with pending runs
        logic held_valid;  // a dispatch result is held back
        logic cnt_last;    // next ready slot fills the result budget
    } stat_t;

    // Slot number masked to the width of the output field
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [SLOT_W+IDX_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

// File: hdl/cooperative_task_tick_scheduler.sv
// Top level of the cooperative task tick scheduler.
// Instantiates ctts_ctrl and ctts_dp; depends on ctts_pkg.

// Time-triggered cooperative scheduler over a table of TASKS slots. One request
// is handled at a time. Add and delete pass through a single-request state that
// loads their result into the output register. Tick and dispatch walk the table
// one slot per cycle, though a dispatch walk can be held as set out below and
// ends early once the result budget is full. The flush state then loads the
// closing result of the walk.
// A busy output stretches the closing step. A dispatch that meets a busy output
// while a result is held waits for the output to be taken. The output register
// lets the next request be accepted while the last result still waits.
// Dispatch returns up to eight beats in slot order with tlast on the final one.
module cooperative_task_tick_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // task_id[2:0], start_delay[10:3], repeat_period[18:11]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // slot[2:0]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);

    ctts_pkg::cmd_t  cmd;
    ctts_pkg::stat_t stat;

    // Sequencer
    ctts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Task table and result path
    ctts_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// File: hdl/ctts_ctrl.sv
// Controller state machine for the task scheduler: sequences requests and walks.
// Depends on ctts_pkg; drives ctts_dp through cmd_t and reads stat_t.
module ctts_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic [1:0]             s_tuser,
    output logic                   s_tready,
    input  ctts_pkg::stat_t        stat,
    output ctts_pkg::cmd_t         cmd
);

    ctts_pkg::state_t state_reg;
    ctts_pkg::state_t state_next;
    ctts_pkg::req_t   req_in;
    logic             disp_go;

    assign req_in  = ctts_pkg::req_t'(s_tuser);
    // Hold the dispatch walk when a second ready slot meets a busy output
    assign disp_go = !(stat.slot_ready && stat.held_valid && !stat.out_free);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ctts_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (req_in)
                        ctts_pkg::REQ_ADD,
                        ctts_pkg::REQ_DEL:  state_next = ctts_pkg::S_SINGLE;
                        ctts_pkg::REQ_TICK: state_next = ctts_pkg::S_TICK;
                        ctts_pkg::REQ_DISP: state_next = ctts_pkg::S_DISP;
                        default:            state_next = ctts_pkg::S_IDLE;
                    endcase
                end
            end
            ctts_pkg::S_SINGLE:
            begin
                if (stat.out_free)
                begin
                    state_next = ctts_pkg::S_IDLE;
                end
            end
            ctts_pkg::S_TICK:
            begin
                if (stat.idx_last)
                begin
                    state_next = ctts_pkg::S_FLUSH;
                end
            end
            ctts_pkg::S_DISP:
            begin
                if (disp_go && (stat.idx_last || (stat.slot_ready && stat.cnt_last)))
                begin
                    state_next = ctts_pkg::S_FLUSH;
                end
            end
            ctts_pkg::S_FLUSH:
            begin
                if (stat.out_free)
                begin
                    state_next = ctts_pkg::S_IDLE;
                end
            end
            default: state_next = ctts_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ctts_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ctts_pkg::S_SINGLE: cmd.exec      = stat.out_free;
            ctts_pkg::S_TICK:   cmd.tick_step = 1'b1;
            ctts_pkg::S_DISP:   cmd.disp_step = disp_go;
            ctts_pkg::S_FLUSH:  cmd.flush     = stat.out_free;
            default:            cmd           = '0;
        endcase
    end

endmodule

// File: hdl/ctts_dp.sv
// Datapath of the task scheduler: task table, walk index, held result, output register.
// Depends on ctts_pkg; commanded by ctts_ctrl.
module ctts_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [1:0]                   s_tuser,
    input  logic [23:0]                  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ctts_pkg::BYTE_W-1:0]  m_tdata,
    output logic [1:0]                   m_tuser,
    output logic                         m_tlast,
    input  ctts_pkg::cmd_t               cmd,
    output ctts_pkg::stat_t              stat
);

    localparam int IDX_W = ctts_pkg::IDX_W;
    localparam int NF_W  = ctts_pkg::NF_W;
    localparam int CNT_W = ctts_pkg::CNT_W;
    localparam int ID_W  = ctts_pkg::SLOT_W + IDX_W;

    // Table storage: valid bits reset, payload written on add, tick and dispatch
    logic [ctts_pkg::TASKS-1:0] valid_reg;
    logic [7:0]                 cd_mem   [ctts_pkg::TASKS];
    logic [7:0]                 rel_mem  [ctts_pkg::TASKS];
    logic [7:0]                 pend_mem [ctts_pkg::TASKS];

    // Latched request
    ctts_pkg::req_t req_reg;
    logic [2:0]     id_reg;
    logic [7:0]     delay_reg;
    logic [7:0]     period_reg;

    // Walk and allocation state
    logic [NF_W-1:0]  nf_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             held_reg;
    logic [IDX_W-1:0] held_idx_reg;

    // Output register
    logic                          out_valid_reg;
    ctts_pkg::status_t             out_status_reg;
    logic [ctts_pkg::SLOT_W-1:0]   out_slot_reg;
    logic                          out_last_reg;

    // Per-cycle table write
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       wr_cd;
    logic [7:0]       wr_rel;
    logic [7:0]       wr_pend;
    logic             vwr_en;
    logic             vwr_val;

    // Output load
    logic                        out_load;
    ctts_pkg::status_t           out_status;
    logic [ctts_pkg::SLOT_W-1:0] out_slot;
    logic                        out_last;

    // Slot under the walk
    logic       cur_valid;
    logic [7:0] cur_cd;
    logic [7:0] cur_rel;
    logic [7:0] cur_pend;
    logic [7:0] cd_dec;

    // Add and delete decode
    logic             nf_ok;
    logic [IDX_W-1:0] nf_idx;
    logic [ID_W-1:0]  id_wide;
    logic             del_ok;
    logic [IDX_W-1:0] del_idx;

    assign cur_valid = valid_reg[idx_reg];
    assign cur_cd    = cd_mem[idx_reg];
    assign cur_rel   = rel_mem[idx_reg];
    assign cur_pend  = pend_mem[idx_reg];
    assign cd_dec    = cur_cd - 8'd1;

    assign nf_ok   = nf_reg < NF_W'(ctts_pkg::TASKS);
    assign nf_idx  = nf_reg[IDX_W-1:0];
    assign id_wide = {{IDX_W{1'b0}}, id_reg};
    assign del_idx = id_wide[IDX_W-1:0];
    assign del_ok  = (id_wide < ID_W'(ctts_pkg::TASKS)) && valid_reg[del_idx];

    // Status towards the controller
    assign stat.out_free   = !out_valid_reg || m_tready;
    assign stat.idx_last   = idx_reg == IDX_W'(ctts_pkg::TASKS - 1);
    assign stat.slot_ready = cur_valid && (cur_pend != 8'd0);
    assign stat.held_valid = held_reg;
    assign stat.cnt_last   = cnt_reg == CNT_W'(ctts_pkg::MAX_OUT - 1);

    // Table update for the command in hand
    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = idx_reg;
        wr_cd   = cur_cd;
        wr_rel  = cur_rel;
        wr_pend = cur_pend;
        vwr_en  = 1'b0;
        vwr_val = 1'b0;
        if (cmd.exec && (req_reg == ctts_pkg::REQ_ADD) && nf_ok)
        begin
            wr_en   = 1'b1;
            wr_idx  = nf_idx;
            wr_cd   = delay_reg + 8'd1;
            wr_rel  = period_reg;
            wr_pend = 8'd0;
            vwr_en  = 1'b1;
            vwr_val = 1'b1;
        end
        else if (cmd.exec && (req_reg == ctts_pkg::REQ_DEL) && del_ok)
        begin
            wr_idx = del_idx;
            vwr_en = 1'b1;
        end
        else if (cmd.tick_step && cur_valid)
        begin
            wr_en = 1'b1;
            if (cd_dec == 8'd0)
            begin
                wr_cd = cur_rel;
                if (cur_pend != 8'hFF)
                begin
                    wr_pend = cur_pend + 8'd1;
                end
            end
            else
            begin
                wr_cd = cd_dec;
            end
        end
        else if (cmd.disp_step && stat.slot_ready)
        begin
            wr_en   = 1'b1;
            wr_pend = cur_pend - 8'd1;
            vwr_en  = cur_rel == 8'd0;
        end
    end

    // Result to load into the output register
    always_comb
    begin
        out_load   = 1'b0;
        out_status = ctts_pkg::STAT_OK;
        out_slot   = '0;
        out_last   = 1'b1;
        if (cmd.exec)
        begin
            out_load = 1'b1;
            if (req_reg == ctts_pkg::REQ_ADD)
            begin
                out_status = nf_ok ? ctts_pkg::STAT_OK : ctts_pkg::STAT_FULL;
                out_slot   = nf_ok ? ctts_pkg::to_slot(nf_idx) : '0;
            end
            else
            begin
                out_status = del_ok ? ctts_pkg::STAT_OK : ctts_pkg::STAT_UNDEF;
            end
        end
        else if (cmd.disp_step && stat.slot_ready && held_reg)
        begin
            out_load = 1'b1;
            out_slot = ctts_pkg::to_slot(held_idx_reg);
            out_last = 1'b0;
        end
        else if (cmd.flush)
        begin
            out_load = 1'b1;
            if (req_reg == ctts_pkg::REQ_DISP)
            begin
                out_status = held_reg ? ctts_pkg::STAT_OK : ctts_pkg::STAT_NONE;
                out_slot   = held_reg ? ctts_pkg::to_slot(held_idx_reg) : '0;
            end
        end
    end

    // Table payload
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cd_mem[wr_idx]   <= wr_cd;
            rel_mem[wr_idx]  <= wr_rel;
            pend_mem[wr_idx] <= wr_pend;
        end
    end

    // Valid bits and allocation pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            nf_reg    <= '0;
        end
        else
        begin
            if (vwr_en)
            begin
                valid_reg[wr_idx] <= vwr_val;
            end
            if (cmd.exec && (req_reg == ctts_pkg::REQ_ADD) && nf_ok)
            begin
                nf_reg <= nf_reg + NF_W'(1);
            end
        end
    end

    // Request latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= ctts_pkg::req_t'(s_tuser);
            id_reg     <= s_tdata[2:0];
            delay_reg  <= s_tdata[10:3];
            period_reg <= s_tdata[18:11];
        end
    end

    // Walk index, result count and held dispatch result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            cnt_reg      <= '0;
            held_reg     <= 1'b0;
            held_idx_reg <= '0;
        end
        else if (cmd.load)
        begin
            idx_reg  <= '0;
            cnt_reg  <= '0;
            held_reg <= 1'b0;
        end
        else if (cmd.tick_step || cmd.disp_step)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (cmd.disp_step && stat.slot_ready)
            begin
                held_reg     <= 1'b1;
                held_idx_reg <= idx_reg;
                cnt_reg      <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= out_status;
            out_slot_reg   <= out_slot;
            out_last_reg   <= out_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(ctts_pkg::BYTE_W - ctts_pkg::SLOT_W){1'b0}}, out_slot_reg};
    assign m_tlast  = out_last_reg;

endmodule
